// ===== rtl/lfbr_pkg.sv =====
// Package for the length-framed byte receiver.
// Holds the word types, parser phase and command codes; no dependencies.
package lfbr_pkg;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'd1;

  localparam logic [7:0] START_BYTE_RESET = 8'h02;
  localparam logic [7:0] END_BYTE_RESET   = 8'h03;
  localparam logic [7:0] COUNT_MAX        = 8'hFF;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } rx_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_done;
    logic [7:0] frame_length;
    logic [1:0] parser_phase;
  } rx_out_t;

endpackage

// ===== rtl/lfbr_ram.sv =====
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
module lfbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/length_framed_byte_receiver.sv =====
// Length-framed byte receiver: start, length, payload, end; ping-pong frame banks.
// A word goes through stage s1, then the output register; a stall holds both.
// One word per cycle unless out_ready stalls; the RAM read sets the extra stage.
// Reset clears the parser, counters, committed bank and config registers;
// the bank RAM is not cleared and needs no clearing pass.
// Depends on lfbr_pkg and lfbr_ram.
module length_framed_byte_receiver #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lfbr_pkg::rx_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lfbr_pkg::rx_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data
);
  import lfbr_pkg::*;

  localparam int RAM_DEPTH = 2 * BUFFER_DEPTH;
  localparam int AW        = $clog2(RAM_DEPTH);

  phase_t      phase, phase_next;
  logic [7:0]  start_byte, end_byte;
  logic [7:0]  expected_length, expected_length_next;
  logic [7:0]  byte_count, byte_count_next, count_inc;
  logic        committed_bank, committed_bank_next;
  logic [7:0]  committed_length, committed_length_next;
  logic [7:0]  committed_count, committed_count_next;
  logic        done;

  logic        in_fire, is_byte, is_read, read_hit;
  logic        s1_valid, s1_move;
  logic        s1_done, s1_rd;
  logic [7:0]  s1_len;
  logic [1:0]  s1_phase;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_move;
  assign in_fire   = in_valid && in_ready;
  assign is_byte   = in_fire && (in_data.command == CMD_BYTE);
  assign is_read   = in_fire && (in_data.command == CMD_READ);
  assign count_inc = (byte_count != COUNT_MAX) ? byte_count + 8'd1 : byte_count;
  assign read_hit  = in_data.read_index < committed_count;

  always_comb begin
    phase_next = phase;
    if (is_byte) begin
      case (phase)
        PH_START: begin
          if (in_data.rx_byte == start_byte) phase_next = PH_LEN;
        end
        PH_LEN:  phase_next = PH_DATA;
        PH_DATA: begin
          if (expected_length <= count_inc) phase_next = PH_END;
        end
        PH_END: begin
          if (in_data.rx_byte == end_byte) phase_next = PH_START;
        end
        default: phase_next = PH_START;
      endcase
    end
  end

  always_comb begin
    expected_length_next  = expected_length;
    byte_count_next       = byte_count;
    committed_bank_next   = committed_bank;
    committed_length_next = committed_length;
    committed_count_next  = committed_count;
    done                  = 1'b0;
    ram_we                = 1'b0;
    if (is_byte) begin
      case (phase)
        PH_LEN:  expected_length_next = in_data.rx_byte;
        PH_DATA: begin
          ram_we          = 1'b1;
          byte_count_next = count_inc;
        end
        PH_END: begin
          if (in_data.rx_byte == end_byte) begin
            committed_bank_next   = !committed_bank;
            committed_length_next = expected_length;
            committed_count_next  = byte_count;
            byte_count_next       = 8'd0;
            done                  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign ram_waddr = AW'(byte_count) + (committed_bank ? '0 : AW'(BUFFER_DEPTH));
  assign ram_raddr = AW'(in_data.read_index) + (committed_bank ? AW'(BUFFER_DEPTH) : '0);
  assign ram_re    = is_read;

  lfbr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_banks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      expected_length  <= 8'd0;
      byte_count       <= 8'd0;
      committed_bank   <= 1'b0;
      committed_length <= 8'd0;
      committed_count  <= 8'd0;
      start_byte       <= START_BYTE_RESET;
      end_byte         <= END_BYTE_RESET;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START_BYTE) start_byte <= cfg_data;
        if (cfg_index == REG_END_BYTE)   end_byte   <= cfg_data;
      end
      phase            <= phase_next;
      expected_length  <= expected_length_next;
      byte_count       <= byte_count_next;
      committed_bank   <= committed_bank_next;
      committed_length <= committed_length_next;
      committed_count  <= committed_count_next;
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_done  <= done;
      s1_len   <= committed_length_next;
      s1_phase <= phase_next;
      s1_rd    <= is_read && read_hit;
    end
    if (s1_move) begin
      out_data.read_data    <= s1_rd ? ram_rdata : 8'd0;
      out_data.frame_done   <= s1_done;
      out_data.frame_length <= s1_len;
      out_data.parser_phase <= s1_phase;
    end
  end

  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("write and read hit the same bank entry");

  a_hold_rdata: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move && s1_rd |=> $stable(ram_rdata))
    else $error("bank read data changed while stage held");

  a_commit: assert property (@(posedge clk) disable iff (rst)
    done |=> byte_count == 8'd0 && committed_bank != $past(committed_bank))
    else $error("commit did not swap banks and clear count");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.parser_phase == PH_START)
    else $error("frame done without return to start phase");

endmodule

// ===== test/lfbr_frame_checker.sv =====
// Scoreboard for the length-framed byte receiver: watches the input, result and register
// channels, predicts each result word from its own parser copy and compares field by field.
// Depends on lfbr_pkg.
module lfbr_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  lfbr_pkg::rx_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  lfbr_pkg::rx_out_t              out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lfbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             failures,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfbr_pkg::*;

  phase_t     ph;
  logic [7:0] open_val;
  logic [7:0] close_val;
  logic [7:0] declared_len;
  logic [7:0] stored_cnt;
  logic       live_bank;
  logic [7:0] live_len;
  logic [8:0] live_cnt;
  logic [7:0] banks [0:1][0:255];
  rx_out_t    status_due[$];

  task automatic advance_parser(input rx_in_t w, output rx_out_t r);
    r = '0;
    if (w.command == CMD_READ) begin
      if ({1'b0, w.read_index} < live_cnt) r.read_data = banks[live_bank][w.read_index];
    end else begin
      case (ph)
        PH_START: if (w.rx_byte == open_val) ph = PH_LEN;
        PH_LEN: begin
          declared_len = w.rx_byte;
          ph = PH_DATA;
        end
        PH_DATA: begin
          banks[!live_bank][stored_cnt] = w.rx_byte;
          if (stored_cnt < COUNT_MAX) stored_cnt = stored_cnt + 8'd1;
          if (declared_len <= stored_cnt) ph = PH_END;
        end
        default: if (w.rx_byte == close_val) begin
          live_bank    = !live_bank;
          live_len     = declared_len;
          live_cnt     = {1'b0, stored_cnt};
          stored_cnt   = 8'd0;
          ph           = PH_START;
          r.frame_done = 1'b1;
        end
      endcase
    end
    r.frame_length = live_len;
    r.parser_phase = ph;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    rx_out_t want;
    if (rst) begin
      ph           = PH_START;
      open_val     = START_BYTE_RESET;
      close_val    = END_BYTE_RESET;
      declared_len = 8'd0;
      stored_cnt   = 8'd0;
      live_bank    = 1'b0;
      live_len     = 8'd0;
      live_cnt     = 9'd0;
      failures     = 0;
      status_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START_BYTE) open_val = cfg_data;
        else if (cfg_index == REG_END_BYTE) close_val = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $error("result word with no prediction waiting: %h", out_data);
          failures++;
        end else begin
          want = status_due.pop_front();
          compare_field("read_data", want.read_data, out_data.read_data);
          compare_field("frame_done", want.frame_done, out_data.frame_done);
          compare_field("frame_length", want.frame_length, out_data.frame_length);
          compare_field("parser_phase", want.parser_phase, out_data.parser_phase);
        end
      end
      if (in_valid && in_ready) begin
        advance_parser(in_data, want);
        status_due.push_back(want);
      end
    end
    pending = status_due.size();
  end

endmodule

// ===== test/length_framed_byte_receiver_test.sv =====
// Top of the length-framed byte receiver bench: clock, reset, framed byte traffic,
// register phases and the verdict. Depends on lfbr_pkg, the block and lfbr_frame_checker.
module length_framed_byte_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lfbr_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  rx_in_t               in_data;
  logic                 out_valid;
  logic                 out_ready;
  rx_out_t              out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  int                   failures;
  int                   pending;

  int         words_sent = 0;
  int         burst_left;
  logic [7:0] start_val = START_BYTE_RESET;
  logic [7:0] end_val = END_BYTE_RESET;

  length_framed_byte_receiver dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lfbr_frame_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #2_000_000;
    $display("length_framed_byte_receiver: mismatch");
    $finish;
  end

  task automatic send_word(input logic cmd, input logic [7:0] rx, input logic [7:0] idx);
    rx_in_t w;
    w.command    = cmd;
    w.rx_byte    = rx;
    w.read_index = idx;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(CMD_BYTE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [7:0] idx);
    send_word(CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  function automatic logic [7:0] near_index();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] not_end_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == end_val) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic send_frame(input int len, input int junk);
    int n;
    n = (len == 0) ? 1 : len;
    send_byte(start_val);
    send_byte(len[7:0]);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    repeat (junk) send_byte(not_end_byte());
    send_byte(end_val);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_START_BYTE) start_val = val;
    else end_val = val;
  endtask

  task automatic run_traffic(input int quota);
    int first;
    int pick;
    int len;
    first = words_sent;
    while (words_sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(16, 64) : $urandom_range(0, 12);
        send_frame(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        repeat ($urandom_range(0, 3)) send_read(near_index());
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) send_read(near_index());
      end else if (pick < 88) begin
        len = $urandom_range(1, 12);
        send_byte(start_val);
        send_byte(len[7:0]);
        repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : drain_side
    int  mode;
    int  seg;
    bit  held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 120);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (k % 3 != 2);
        endcase
        @(posedge clk);
      end
      if (!held_off && words_sent >= 60) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] same;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_START_BYTE;
    cfg_data  <= 8'h00;
    burst_left = $urandom_range(1, 10);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_read(8'd0);
    send_read(8'd255);
    send_byte(8'hFF);
    send_byte(END_BYTE_RESET);
    send_byte(START_BYTE_RESET);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(END_BYTE_RESET);
    send_read(8'd0);
    send_read(8'd1);
    send_byte(START_BYTE_RESET);
    send_byte(START_BYTE_RESET);
    send_read(8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(END_BYTE_RESET);
    send_read(8'd1);
    send_read(8'd2);
    send_read(8'd255);

    run_traffic(100);

    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'hFF);
    send_frame(255, 0);
    send_read(8'd254);
    send_read(8'd255);
    run_traffic(100);

    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_END_BYTE, 8'h00);
    run_traffic(100);

    same = 8'($urandom_range(0, 255));
    write_reg(REG_START_BYTE, same);
    write_reg(REG_END_BYTE, same);
    run_traffic(100);

    write_reg(REG_END_BYTE, 8'($urandom_range(0, 255)));
    write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
    run_traffic(100);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("length_framed_byte_receiver: match");
    end else begin
      $display("length_framed_byte_receiver: mismatch");
    end
    $finish;
  end

endmodule
